[rtl/srie_pkg.sv]
// Package for the split ring index engine: operation and register codes,
// the state machine type, the store control struct and port widths.
// No dependencies.
`default_nettype none

package srie_pkg;

    // port widths
    localparam int OP_W        = 3;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 104;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int IDX_W       = 16;
    localparam int LEN_W       = 32;

    // operation codes carried in s_tuser
    typedef enum logic [OP_W-1:0] {
        OP_WR_AVAIL      = 3'd0,
        OP_PUBLISH       = 3'd1,
        OP_WR_USED_EVENT = 3'd2,
        OP_POP           = 3'd3,
        OP_PUSH          = 3'd4,
        OP_NOTIFY        = 3'd5,
        OP_RD_USED       = 3'd6,
        OP_RD_IDX        = 3'd7
    } op_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUEUE_SIZE   = 2'd0,
        CFG_EVENT_IDX    = 2'd1,
        CFG_QUEUE_READY  = 2'd2
    } cfg_reg_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MOD,
        ST_MEM,
        ST_DONE
    } state_t;

    // ring store strobes
    typedef struct packed {
        logic avail_we;
        logic avail_re;
        logic used_we;
        logic used_re;
    } mem_ctl_t;

endpackage

`default_nettype wire

[rtl/srie_mod_unit.sv]
// Iterative remainder unit: 16-bit index modulo the effective queue size,
// two quotient bits per cycle. Uses srie_pkg for the index width.
`default_nettype none

module srie_mod_unit #(
    parameter int QW = 9
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [srie_pkg::IDX_W-1:0] dividend,
    input  wire logic [QW-1:0]              divisor,
    output logic                            done,
    output logic [QW-1:0]                   remainder
);

    localparam int STEPS = srie_pkg::IDX_W / 2;
    localparam int CW    = $clog2(STEPS);
    localparam logic [CW-1:0] LAST_STEP = CW'(STEPS - 1);

    logic                       busy_reg;
    logic                       done_reg;
    logic [CW-1:0]              cnt_reg;
    logic [srie_pkg::IDX_W-1:0] dividend_reg;
    logic [QW-1:0]              divisor_reg;
    logic [QW-1:0]              rem_reg;

    logic [QW:0]   trial1;
    logic [QW:0]   sub1;
    logic [QW-1:0] rem1;
    logic [QW:0]   trial2;
    logic [QW:0]   sub2;
    logic [QW-1:0] rem2;

    // two restoring steps; remainder stays below the divisor
    always_comb begin
        trial1 = {rem_reg, dividend_reg[srie_pkg::IDX_W-1]};
        sub1   = (trial1 >= {1'b0, divisor_reg}) ? (trial1 - {1'b0, divisor_reg}) : trial1;
        rem1   = sub1[QW-1:0];
        trial2 = {rem1, dividend_reg[srie_pkg::IDX_W-2]};
        sub2   = (trial2 >= {1'b0, divisor_reg}) ? (trial2 - {1'b0, divisor_reg}) : trial2;
        rem2   = sub2[QW-1:0];
    end

    // iteration control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg     <= 1'b1;
                cnt_reg      <= '0;
                dividend_reg <= dividend;
                divisor_reg  <= divisor;
                rem_reg      <= '0;
            end else if (busy_reg) begin
                rem_reg      <= rem2;
                dividend_reg <= {dividend_reg[srie_pkg::IDX_W-3:0], 2'b00};
                cnt_reg      <= cnt_reg + CW'(1);
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

[rtl/srie_ring_store.sv]
// Avail and used ring stores: single-port synchronous memories with a
// registered read. Uses srie_pkg for the control struct and widths.
`default_nettype none

module srie_ring_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic                       aclk,
    input  wire srie_pkg::mem_ctl_t         ctl,
    input  wire logic [AW-1:0]              addr,
    input  wire logic [srie_pkg::IDX_W-1:0] avail_wdata,
    input  wire logic [srie_pkg::IDX_W-1:0] used_wid,
    input  wire logic [srie_pkg::LEN_W-1:0] used_wlen,
    output logic [srie_pkg::IDX_W-1:0]      avail_rdata,
    output logic [srie_pkg::IDX_W-1:0]      used_rid,
    output logic [srie_pkg::LEN_W-1:0]      used_rlen
);

    localparam int UW = srie_pkg::IDX_W + srie_pkg::LEN_W;

    logic [srie_pkg::IDX_W-1:0] avail_mem [DEPTH];
    logic [UW-1:0]              used_mem  [DEPTH];
    logic [srie_pkg::IDX_W-1:0] avail_q_reg;
    logic [UW-1:0]              used_q_reg;

    // avail ring
    always_ff @(posedge aclk) begin
        if (ctl.avail_we) begin
            avail_mem[addr] <= avail_wdata;
        end
        if (ctl.avail_re) begin
            avail_q_reg <= avail_mem[addr];
        end
    end

    // used ring, length in the upper bits
    always_ff @(posedge aclk) begin
        if (ctl.used_we) begin
            used_mem[addr] <= {used_wlen, used_wid};
        end
        if (ctl.used_re) begin
            used_q_reg <= used_mem[addr];
        end
    end

    assign avail_rdata = avail_q_reg;
    assign used_rid    = used_q_reg[srie_pkg::IDX_W-1:0];
    assign used_rlen   = used_q_reg[UW-1:srie_pkg::IDX_W];

endmodule

`default_nettype wire

[rtl/split_ring_index_engine_unit.sv]
// Top level of the split ring index engine: sequencer, index registers,
// config registers and output register. Uses srie_pkg, srie_mod_unit
// and srie_ring_store.
//
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+------------------------------
//  s_       | in        | s_tvalid/tready  | s_tuser op, s_tdata fields
//  m_       | out       | m_tvalid/tready  | m_tdata result fields
//  cfg_     | in        | cfg_wr_en        | cfg_index, cfg_wdata
//
// From accept, every op passes the execute and done states; a push adds
// the remainder wait, an in-range used slot read adds the store read state,
// and a successful pop adds both (8-step remainder unit plus registered
// store read). s_tready returns the cycle after the result loads. A held
// output register keeps the sequencer in its done state with s_tready low.
// Reset clears the state, index and config registers and output valid only.
`default_nettype none

module split_ring_index_engine_unit #(
    parameter int MAX_QUEUE_DEPTH = 256
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // input transactions
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // op
    input  wire logic [srie_pkg::OP_W-1:0]          s_tuser,
    // ring_slot, index_value, no_interrupt, head_id, used_length, zero pad
    input  wire logic [srie_pkg::IN_TDATA_W-1:0]    s_tdata,
    // result transactions
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // ok, popped_head, notify, slot_id, slot_length, used_index_out,
    // avail_event_out, zero pad
    output logic [srie_pkg::OUT_TDATA_W-1:0]        m_tdata,
    // configuration writes
    input  wire logic                               cfg_wr_en,
    input  wire logic [srie_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [srie_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int AW    = $clog2(MAX_QUEUE_DEPTH);
    localparam int QW    = $clog2(MAX_QUEUE_DEPTH + 1);
    localparam int IW    = srie_pkg::IDX_W;
    localparam int LW    = srie_pkg::LEN_W;
    localparam int RES_W = 1 + IW + 1 + IW + LW + IW + IW;
    localparam logic [16:0] MAX_W = 17'(MAX_QUEUE_DEPTH);

    // state and registers
    srie_pkg::state_t state_reg;
    srie_pkg::state_t state_next;

    srie_pkg::op_t op_reg;
    logic [7:0]    slot_reg;
    logic [IW-1:0] val_reg;
    logic          noint_reg;
    logic [IW-1:0] hid_reg;
    logic [LW-1:0] len_reg;

    logic [8:0]    queue_size_reg;
    logic          event_idx_reg;
    logic          queue_ready_reg;

    logic [IW-1:0] driver_idx_reg;
    logic          suppress_reg;
    logic [IW-1:0] used_event_reg;
    logic [IW-1:0] last_seen_reg;
    logic [IW-1:0] used_index_reg;
    logic [IW-1:0] avail_event_reg;
    logic [IW-1:0] last_sig_reg;

    logic          res_ok_reg;
    logic [IW-1:0] res_head_reg;
    logic          res_notify_reg;
    logic [IW-1:0] res_id_reg;
    logic [LW-1:0] res_len_reg;
    logic [IW-1:0] res_uidx_reg;
    logic [IW-1:0] res_aevt_reg;

    logic                            m_tvalid_reg;
    logic [srie_pkg::OUT_TDATA_W-1:0] m_tdata_reg;

    // combinational helpers
    logic [QW-1:0] qs;
    logic [16:0]   q_ext;
    logic [IW-1:0] slot_ext;
    logic [AW-1:0] slot_addr;
    logic          slot_in_range;
    logic          pop_ok;
    logic          out_free;
    logic [IW-1:0] evt_a;
    logic [IW-1:0] evt_b;
    logic          s_accept;

    srie_pkg::mem_ctl_t mem_ctl;
    logic [AW-1:0]      mem_addr;
    logic [IW-1:0]      avail_rdata;
    logic [IW-1:0]      used_rid;
    logic [LW-1:0]      used_rlen;

    logic          mod_start;
    logic [IW-1:0] mod_dividend;
    logic          mod_done;
    logic [QW-1:0] mod_rem;

    // effective queue size clamped to 1..depth
    always_comb begin
        q_ext = {8'b0, queue_size_reg};
        if (q_ext > MAX_W) begin
            qs = MAX_W[QW-1:0];
        end else if (queue_size_reg == 9'd0) begin
            qs = QW'(1);
        end else begin
            qs = q_ext[QW-1:0];
        end
    end

    // slot and pop checks
    assign slot_ext      = {8'b0, slot_reg};
    assign slot_addr     = slot_ext[AW-1:0];
    assign slot_in_range = ({9'b0, slot_reg} < 17'(qs));
    assign pop_ok        = queue_ready_reg && (last_seen_reg != driver_idx_reg);
    assign out_free      = !m_tvalid_reg || m_tready;
    assign s_accept      = s_tvalid && s_tready;

    // event index distances
    assign evt_a = used_index_reg - used_event_reg - IW'(1);
    assign evt_b = used_index_reg - last_sig_reg;

    assign mod_dividend = (op_reg == srie_pkg::OP_POP) ? last_seen_reg : used_index_reg;

    srie_mod_unit #(
        .QW(QW)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (mod_dividend),
        .divisor   (qs),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    srie_ring_store #(
        .DEPTH(MAX_QUEUE_DEPTH),
        .AW   (AW)
    ) u_store (
        .aclk        (aclk),
        .ctl         (mem_ctl),
        .addr        (mem_addr),
        .avail_wdata (val_reg),
        .used_wid    (hid_reg),
        .used_wlen   (len_reg),
        .avail_rdata (avail_rdata),
        .used_rid    (used_rid),
        .used_rlen   (used_rlen)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            srie_pkg::ST_IDLE: begin
                if (s_accept) state_next = srie_pkg::ST_EXEC;
            end
            srie_pkg::ST_EXEC: begin
                case (op_reg)
                    srie_pkg::OP_POP:     state_next = pop_ok ? srie_pkg::ST_MOD
                                                              : srie_pkg::ST_DONE;
                    srie_pkg::OP_PUSH:    state_next = srie_pkg::ST_MOD;
                    srie_pkg::OP_RD_USED: state_next = slot_in_range ? srie_pkg::ST_MEM
                                                                     : srie_pkg::ST_DONE;
                    default:              state_next = srie_pkg::ST_DONE;
                endcase
            end
            srie_pkg::ST_MOD: begin
                if (mod_done) begin
                    state_next = (op_reg == srie_pkg::OP_POP) ? srie_pkg::ST_MEM
                                                              : srie_pkg::ST_DONE;
                end
            end
            srie_pkg::ST_MEM: state_next = srie_pkg::ST_DONE;
            srie_pkg::ST_DONE: begin
                if (out_free) state_next = srie_pkg::ST_IDLE;
            end
            default: state_next = srie_pkg::ST_IDLE;
        endcase
    end

    // state outputs: handshake, store strobes, remainder start
    always_comb begin
        s_tready  = 1'b0;
        mem_ctl   = '0;
        mem_addr  = slot_addr;
        mod_start = 1'b0;
        unique case (state_reg)
            srie_pkg::ST_IDLE: s_tready = 1'b1;
            srie_pkg::ST_EXEC: begin
                case (op_reg)
                    srie_pkg::OP_WR_AVAIL: mem_ctl.avail_we = slot_in_range;
                    srie_pkg::OP_RD_USED:  mem_ctl.used_re  = slot_in_range;
                    srie_pkg::OP_POP:      mod_start        = pop_ok;
                    srie_pkg::OP_PUSH:     mod_start        = 1'b1;
                    default:               mem_ctl          = '0;
                endcase
            end
            srie_pkg::ST_MOD: begin
                mem_addr = mod_rem[AW-1:0];
                if (mod_done) begin
                    mem_ctl.avail_re = (op_reg == srie_pkg::OP_POP);
                    mem_ctl.used_we  = (op_reg == srie_pkg::OP_PUSH);
                end
            end
            srie_pkg::ST_MEM:  mem_ctl = '0;
            srie_pkg::ST_DONE: mem_ctl = '0;
            default:           mem_ctl = '0;
        endcase
    end

    // input capture
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg    <= srie_pkg::op_t'(s_tuser);
            slot_reg  <= s_tdata[7:0];
            val_reg   <= s_tdata[23:8];
            noint_reg <= s_tdata[24];
            hid_reg   <= s_tdata[40:25];
            len_reg   <= s_tdata[72:41];
        end
    end

    // state, config and ring indices
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= srie_pkg::ST_IDLE;
            queue_size_reg  <= 9'd256;
            event_idx_reg   <= 1'b0;
            queue_ready_reg <= 1'b0;
            driver_idx_reg  <= '0;
            suppress_reg    <= 1'b0;
            used_event_reg  <= '0;
            last_seen_reg   <= '0;
            used_index_reg  <= '0;
            avail_event_reg <= '0;
            last_sig_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    srie_pkg::CFG_QUEUE_SIZE:  queue_size_reg  <= cfg_wdata;
                    srie_pkg::CFG_EVENT_IDX:   event_idx_reg   <= cfg_wdata[0];
                    srie_pkg::CFG_QUEUE_READY: queue_ready_reg <= cfg_wdata[0];
                    default:                   queue_ready_reg <= queue_ready_reg;
                endcase
            end
            if (state_reg == srie_pkg::ST_EXEC) begin
                case (op_reg)
                    srie_pkg::OP_PUBLISH: begin
                        driver_idx_reg <= val_reg;
                        suppress_reg   <= noint_reg;
                    end
                    srie_pkg::OP_WR_USED_EVENT: used_event_reg <= val_reg;
                    srie_pkg::OP_NOTIFY: begin
                        if (event_idx_reg && (evt_a < evt_b)) last_sig_reg <= used_index_reg;
                    end
                    default: last_sig_reg <= last_sig_reg;
                endcase
            end
            // push lands in the store this cycle
            if (state_reg == srie_pkg::ST_MOD && mod_done && op_reg == srie_pkg::OP_PUSH) begin
                used_index_reg <= used_index_reg + IW'(1);
            end
            if (state_reg == srie_pkg::ST_MEM && op_reg == srie_pkg::OP_POP) begin
                last_seen_reg <= last_seen_reg + IW'(1);
                if (event_idx_reg) avail_event_reg <= last_seen_reg + IW'(1);
            end
        end
    end

    // result assembly
    always_ff @(posedge aclk) begin
        if (state_reg == srie_pkg::ST_EXEC) begin
            res_ok_reg     <= 1'b1;
            res_head_reg   <= '0;
            res_notify_reg <= 1'b0;
            res_id_reg     <= '0;
            res_len_reg    <= '0;
            res_uidx_reg   <= '0;
            res_aevt_reg   <= '0;
            case (op_reg)
                srie_pkg::OP_WR_AVAIL: res_ok_reg <= slot_in_range;
                srie_pkg::OP_RD_USED:  res_ok_reg <= slot_in_range;
                srie_pkg::OP_POP:      res_ok_reg <= pop_ok;
                srie_pkg::OP_NOTIFY: begin
                    res_notify_reg <= event_idx_reg ? (evt_a < evt_b) : !suppress_reg;
                end
                srie_pkg::OP_RD_IDX: begin
                    res_uidx_reg <= used_index_reg;
                    res_aevt_reg <= avail_event_reg;
                end
                default: res_ok_reg <= 1'b1;
            endcase
        end else if (state_reg == srie_pkg::ST_MEM) begin
            if (op_reg == srie_pkg::OP_POP) begin
                res_head_reg <= avail_rdata;
            end else begin
                res_id_reg  <= used_rid;
                res_len_reg <= used_rlen;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == srie_pkg::ST_DONE && out_free) begin
            m_tvalid_reg <= 1'b1;
            m_tdata_reg  <= {(srie_pkg::OUT_TDATA_W - RES_W)'(0),
                             res_aevt_reg, res_uidx_reg, res_len_reg, res_id_reg,
                             res_notify_reg, res_head_reg, res_ok_reg};
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    // an accepted transaction goes straight to execution
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == srie_pkg::ST_EXEC)
        else $error("accepted transaction did not enter execution");

    // remainder results only arrive while the sequencer waits for them
    a_mod_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_done |-> state_reg == srie_pkg::ST_MOD)
        else $error("remainder done outside of wait state");

    // a store is never read and written in the same cycle
    a_store_port: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_ctl.avail_we && mem_ctl.avail_re) && !(mem_ctl.used_we && mem_ctl.used_re))
        else $error("store read and write collide");

    // a successful pop advances last seen index by exactly one
    a_pop_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == srie_pkg::ST_MEM && op_reg == srie_pkg::OP_POP)
        |=> last_seen_reg == $past(last_seen_reg) + IW'(1))
        else $error("pop did not advance last seen index");

    // new results are loaded only from the done state
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == srie_pkg::ST_DONE))
        else $error("result loaded outside done state");
`endif

endmodule

`default_nettype wire
